// ----- sv/linear_array_queue_macros.svh -----
// assertion macros for the linear array queue checker
// no dependencies; included by files that hold concurrent assertions
`ifndef LINEAR_ARRAY_QUEUE_MACROS_SVH
`define LINEAR_ARRAY_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LAQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define LAQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/laq_pkg.sv -----
// shared types and constants for the linear array queue
// no dependencies; imported by linear_array_queue, laq_ctrl and laq_checker
`timescale 1ns / 1ps

package laq_pkg;

  // queue geometry
  localparam int DEPTH    = 8;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int DATA_W   = 32;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // stream word widths
  localparam int S_TDATA_W = ((DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + 2 + 7) / 8) * 8;

  // input opcodes
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_TRAV = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // one result word
  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  data;
    logic               is_full;
    logic               is_empty;
    logic               last;
  } res_t;

  // slot memory access request
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [DATA_W-1:0]  wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

// ----- sv/linear_array_queue.sv -----
// linear array queue: enqueue and any op on an empty queue give their word in the
// output register in the cycle after acceptance, one item per cycle while the output is free
// dequeue and peek go through the slot ram read register; no new op until the item ends
// traverse of n entries: first word by that path, then one per cycle while the output is free
// reset clears head, tail and the entries flag; slot contents are kept and never cleared
// top level; depends on laq_pkg, laq_ctrl and laq_ram
`timescale 1ns / 1ps

module linear_array_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [laq_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // value
  input  logic [1:0]                        s_axis_tuser,  // opcode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [laq_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // data, is_full, is_empty, zero pad
  output logic [1:0]                        m_axis_tuser,  // status
  output logic                              m_axis_tlast
);
  import laq_pkg::*;

  logic              out_valid_q;
  res_t              out_q;
  logic              out_free;
  logic              res_valid;
  res_t              res;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  assign out_free = !out_valid_q || m_axis_tready;

  // sequencer
  laq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tuser)),
    .in_value_i  (s_axis_tdata[DATA_W-1:0]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // slot storage
  laq_ram #(
    .Depth (DEPTH),
    .Width (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  // output word packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - 2){1'b0}}, out_q.is_empty, out_q.is_full,
                          out_q.data};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule

// ----- sv/laq_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; holds the queue slots
`timescale 1ns / 1ps

module laq_ram #(
  parameter int Depth = 8,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/laq_ctrl.sv -----
// queue sequencer: head/tail bookkeeping, slot reads and writes, result words
// depends on laq_pkg; drives laq_ram and the output register in the top level
`timescale 1ns / 1ps

module laq_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  laq_pkg::op_e                    in_op_i,
  input  logic [laq_pkg::DATA_W-1:0]      in_value_i,
  input  logic                            out_free_i,
  output logic                            res_valid_o,
  output laq_pkg::res_t                   res_o,
  output laq_pkg::ram_req_t               ram_req_o,
  input  logic [laq_pkg::DATA_W-1:0]      ram_rdata_i
);
  import laq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic             state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic             hold_q, hold_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] end_q, end_d;
  logic             more_q, more_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic             fl_full_q, fl_full_d;
  logic             fl_empty_q, fl_empty_d;
  logic             full;
  logic             load;
  logic             issue;

  assign full = hold_q && (tail_q == LAST_IDX);

  // next state and result generation
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    hold_d      = hold_q;
    cur_d       = cur_q;
    end_d       = end_q;
    more_d      = more_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    fl_full_d   = fl_full_q;
    fl_empty_d  = fl_empty_q;
    ram_req_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    in_ready_o  = 1'b0;
    load        = 1'b0;
    issue       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = out_free_i;
        if (in_valid_i && out_free_i) begin
          res_o.last = 1'b1;
          unique case (in_op_i)
            OP_ENQ: begin
              res_valid_o = 1'b1;
              if (full) begin
                res_o.status   = ST_OVERFLOW;
                res_o.is_full  = 1'b1;
                res_o.is_empty = 1'b0;
              end else begin
                ram_req_o.we    = 1'b1;
                ram_req_o.wdata = in_value_i;
                if (!hold_q) begin
                  head_d          = '0;
                  tail_d          = '0;
                  hold_d          = 1'b1;
                  ram_req_o.waddr = '0;
                end else begin
                  tail_d          = IDX_W'(tail_q + 1'b1);
                  ram_req_o.waddr = IDX_W'(tail_q + 1'b1);
                end
                res_o.status   = ST_OK;
                res_o.is_full  = (tail_d == LAST_IDX);
                res_o.is_empty = 1'b0;
              end
            end
            OP_DEQ, OP_PEEK, OP_TRAV: begin
              if (!hold_q) begin
                // empty queue: single underflow word
                res_valid_o    = 1'b1;
                res_o.status   = ST_UNDERFLOW;
                res_o.is_full  = 1'b0;
                res_o.is_empty = 1'b1;
              end else begin
                state_d    = S_BUSY;
                cur_d      = head_q;
                more_d     = 1'b1;
                end_d      = (in_op_i == OP_TRAV) ? tail_q : head_q;
                fl_full_d  = full;
                fl_empty_d = 1'b0;
                if (in_op_i == OP_DEQ) begin
                  if (head_q == tail_q) begin
                    head_d     = '0;
                    tail_d     = '0;
                    hold_d     = 1'b0;
                    fl_full_d  = 1'b0;
                    fl_empty_d = 1'b1;
                  end else begin
                    head_d = IDX_W'(head_q + 1'b1);
                  end
                end
              end
            end
          endcase
        end
      end
      S_BUSY: begin
        // move read data to the output, then issue the next read
        load  = pend_q && out_free_i;
        issue = more_q && (!pend_q || load);
        if (load) begin
          res_valid_o    = 1'b1;
          res_o.status   = ST_OK;
          res_o.data     = ram_rdata_i;
          res_o.is_full  = fl_full_q;
          res_o.is_empty = fl_empty_q;
          res_o.last     = pend_last_q;
          pend_d         = 1'b0;
          if (pend_last_q) begin
            state_d = S_IDLE;
          end
        end
        if (issue) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = cur_q;
          pend_d          = 1'b1;
          pend_last_d     = (cur_q == end_q);
          more_d          = (cur_q != end_q);
          cur_d           = IDX_W'(cur_q + 1'b1);
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      hold_q  <= 1'b0;
      more_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      hold_q  <= hold_d;
      more_q  <= more_d;
      pend_q  <= pend_d;
    end
  end

  // walk registers and result flags
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    end_q       <= end_d;
    pend_last_q <= pend_last_d;
    fl_full_q   <= fl_full_d;
    fl_empty_q  <= fl_empty_d;
  end

endmodule

// ----- sv/laq_checker.sv -----
// port-level checker for the linear array queue, bound to the top level
// depends on laq_pkg and linear_array_queue_macros.svh
`timescale 1ns / 1ps
`include "linear_array_queue_macros.svh"

module laq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [laq_pkg::M_TDATA_W-1:0] m_axis_tdata,  // data, is_full, is_empty, zero pad
  input logic [1:0]                    m_axis_tuser,  // status
  input logic                          m_axis_tlast
);
  import laq_pkg::*;

  // a stalled word holds
  `LAQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled word changed")

  // no word is taken in while a result waits on a stall
  `LAQ_ASSERT_IMP(a_no_accept_stalled, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !(m_axis_tvalid && !m_axis_tready), "word accepted while output stalled")

  // full and empty never together
  `LAQ_ASSERT_IMP(a_full_empty, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[DATA_W] && m_axis_tdata[DATA_W+1]), "full and empty both set")

  // overflow only reported on a full queue
  `LAQ_ASSERT_IMP(a_ovf_full, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == ST_OVERFLOW), m_axis_tdata[DATA_W] && !m_axis_tdata[DATA_W+1], "overflow without full queue")

  // error words carry zero data and close the item
  `LAQ_ASSERT_IMP(a_err_word, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tlast && (m_axis_tdata[DATA_W-1:0] == '0), "error word with data or without last")

endmodule

bind linear_array_queue laq_checker u_laq_checker (.*);
